// ===== rtl/mbt_pkg.sv =====
package mbt_pkg;

    localparam int MSG_DEPTH_DEFAULT = 64;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 6;
    localparam int LEN_W   = 7;
    localparam int PER_W   = 16;
    localparam int TICK_W  = 17;
    localparam int BIT_W   = 3;

    localparam logic [PER_W-1:0]  BIT_PERIOD_RESET = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX         = {TICK_W{1'b1}};
    localparam logic [BIT_W-1:0]  LAST_BIT         = {BIT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] byte_value;
        logic [SLOT_W-1:0] byte_slot;
        logic [LEN_W-1:0]  msg_length;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic finished;
    } t_result;

endpackage

// ===== rtl/mbt_in_if.sv =====
interface mbt_in_if;
    import mbt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [BYTE_W-1:0]   byte_value;
    logic [SLOT_W-1:0]   byte_slot;
    logic [LEN_W-1:0]    msg_length;

    modport source (output valid, output op, output byte_value, output byte_slot,
                    output msg_length, input ready);
    modport sink   (input valid, input op, input byte_value, input byte_slot,
                    input msg_length, output ready);
endinterface

// ===== rtl/mbt_out_if.sv =====
interface mbt_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic finished;

    modport source (output valid, output line_level, output finished, input ready);
    modport sink   (input valid, input line_level, input finished, output ready);
endinterface

// ===== rtl/mbt_cfg_if.sv =====
interface mbt_cfg_if;
    import mbt_pkg::*;

    logic             valid;
    logic             ready;
    logic [PER_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mbt_ram.sv =====
module mbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the contents before a same-cycle write
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/mbt_core.sv =====
module mbt_core import mbt_pkg::*; #(
    parameter int MSG_DEPTH = MSG_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  t_item            i_item,
    input  logic [PER_W-1:0] i_bit_period,
    output t_result          o_result
);
    localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;

    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic [TICK_W-1:0] r_interval, n_interval;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic              r_second, n_second;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_done, n_done;
    logic              r_level, n_level;
    logic              r_fwd_hit;
    logic [BYTE_W-1:0] r_fwd_data;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] cur_byte;
    logic              cur_bit;
    logic [TICK_W-1:0] elapsed_inc;
    logic [LEN_W-1:0]  next_pos;

    assign wr_en   = i_go && (i_item.op == OP_WRITE) && (32'(i_item.byte_slot) < MSG_DEPTH);
    assign wr_addr = AW'(i_item.byte_slot);
    // fetch the byte of the position that holds after this item
    assign rd_addr = AW'(n_pos);

    mbt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MSG_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.byte_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if (32'(r_pos) >= MSG_DEPTH) begin
            cur_byte = '0;
        end else if (r_fwd_hit) begin
            cur_byte = r_fwd_data;
        end else begin
            cur_byte = rd_data;
        end
        cur_bit     = cur_byte[r_bit];
        elapsed_inc = (r_elapsed != TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        next_pos    = {1'b0, r_pos} + 1'b1;

        n_elapsed  = r_elapsed;
        n_interval = r_interval;
        n_bit      = r_bit;
        n_pos      = r_pos;
        n_second   = r_second;
        n_len      = r_len;
        n_done     = r_done;
        n_level    = r_level;

        if (i_go) begin
            case (i_item.op)
                OP_START: begin
                    if (32'(i_item.msg_length) > MSG_DEPTH) begin
                        n_len = LEN_W'(MSG_DEPTH);
                    end else begin
                        n_len = i_item.msg_length;
                    end
                    n_done = 1'b0;
                end
                OP_TICK: begin
                    if (!r_done) begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= r_interval) begin
                            n_elapsed  = '0;
                            n_interval = TICK_W'(i_bit_period >> 1);
                            if (!r_second) begin
                                n_level  = ~cur_bit;
                                n_second = 1'b1;
                            end else begin
                                n_level  = cur_bit;
                                n_second = 1'b0;
                                n_bit    = r_bit + 1'b1;
                                // byte done: gap of two bit periods, line low
                                if (r_bit == LAST_BIT) begin
                                    n_interval = {i_bit_period, 1'b0};
                                    n_level    = 1'b0;
                                    if (next_pos >= r_len) begin
                                        n_done = 1'b1;
                                        n_pos  = '0;
                                    end else begin
                                        n_pos  = next_pos[SLOT_W-1:0];
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.line_level = n_level;
        o_result.finished   = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed  <= '0;
            r_interval <= TICK_W'(BIT_PERIOD_RESET >> 1);
            r_bit      <= '0;
            r_pos      <= '0;
            r_second   <= 1'b0;
            r_len      <= '0;
            r_done     <= 1'b1;
            r_level    <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_elapsed  <= n_elapsed;
            r_interval <= n_interval;
            r_bit      <= n_bit;
            r_pos      <= n_pos;
            r_second   <= n_second;
            r_len      <= n_len;
            r_done     <= n_done;
            r_level    <= n_level;
            // patch the store read when a write lands on the fetched entry
            r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
        end
        r_fwd_data <= i_item.byte_value;
    end
endmodule

// ===== rtl/manchester_byte_transmitter.sv =====
// channel | dir | handshake     | payload
// i_in    | in  | valid / ready | op, byte_value, byte_slot, msg_length
// o_out   | out | valid / ready | line_level, finished
// i_cfg   | in  | valid / ready | data (bit_period, ticks per bit)
// One item per clock while the output is not stalled: an item is held in the
// input register and its result enters the output register when it moves on.
// The message store is read ahead at the position that follows each item,
// so the byte of a new position is ready for the next item.
// Reset (synchronous, active low) idles the line low with finished high.
// A stalled output holds both registers; the input accepts while either moves.
module manchester_byte_transmitter import mbt_pkg::*; #(
    parameter int MSG_DEPTH = MSG_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbt_in_if.sink    i_in,
    mbt_out_if.source o_out,
    mbt_cfg_if.sink   i_cfg
);
    logic             r_in_valid;
    t_item            r_item;
    logic             r_out_valid;
    t_result          r_res;
    logic [PER_W-1:0] r_bit_period;
    t_result          core_res;
    logic             go;

    assign go          = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || go;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.line_level = r_res.line_level;
    assign o_out.finished   = r_res.finished;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bit_period <= BIT_PERIOD_RESET;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_bit_period <= i_cfg.data;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_item.op         <= t_op'(i_in.op);
            r_item.byte_value <= i_in.byte_value;
            r_item.byte_slot  <= i_in.byte_slot;
            r_item.msg_length <= i_in.msg_length;
        end
        if (go) begin
            r_res <= core_res;
        end
    end

    mbt_core #(
        .MSG_DEPTH (MSG_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_item       (r_item),
        .i_bit_period (r_bit_period),
        .o_result     (core_res)
    );

`ifndef SYNTHESIS
    a_start_clears_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (r_item.op == OP_START) |=> !r_res.finished)
        else $error("start item did not clear finished");

    a_finished_line_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.finished |-> !r_res.line_level)
        else $error("line high while finished");

    a_item_holds_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !go |=> r_in_valid && $stable(r_item))
        else $error("pending item lost during stall");

    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> r_out_valid)
        else $error("processed item produced no result");
`endif
endmodule

// ===== bench/manchester_byte_transmitter_tb.sv =====
`timescale 1ns / 1ps

module manchester_byte_transmitter_tb import mbt_pkg::*; ();

    localparam int MSG_DEPTH   = MSG_DEPTH_DEFAULT;
    localparam int ITEM_GOAL   = 1400;
    localparam int HOLD_AT     = 1000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 5_000_000;

    localparam t_result IDLE_LOW = '{line_level: 1'b0, finished: 1'b1};
    localparam t_result BUSY_LOW = '{line_level: 1'b0, finished: 1'b0};

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] val;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [15:0]       reps;
        logic              typed;
        t_result           want;
    } t_row;

    // Runs at a bit period of 2; the first half-bit still waits out the
    // reset interval of 50 ticks.
    localparam t_row DIRECTED_PLAN [21] = '{
        '{OP_NOP,   8'hFF, 6'd63, 7'd127, 16'd1,  1'b1, IDLE_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd2,  1'b1, IDLE_LOW},
        '{OP_WRITE, 8'hA5, 6'd0,  7'd0,   16'd1,  1'b1, IDLE_LOW},
        '{OP_WRITE, 8'hFF, 6'd63, 7'd0,   16'd1,  1'b1, IDLE_LOW},
        '{OP_WRITE, 8'h00, 6'd1,  7'd0,   16'd1,  1'b1, IDLE_LOW},
        '{OP_START, 8'h00, 6'd0,  7'd0,   16'd1,  1'b1, BUSY_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd49, 1'b1, BUSY_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd16, 1'b0, IDLE_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd1,  1'b1, IDLE_LOW},
        '{OP_START, 8'h00, 6'd0,  7'd2,   16'd1,  1'b1, BUSY_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd4,  1'b0, IDLE_LOW},
        '{OP_START, 8'h00, 6'd0,  7'd1,   16'd1,  1'b0, IDLE_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd15, 1'b0, IDLE_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd1,  1'b1, IDLE_LOW},
        '{OP_START, 8'h00, 6'd0,  7'd2,   16'd1,  1'b0, IDLE_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd20, 1'b0, IDLE_LOW},
        '{OP_WRITE, 8'h5A, 6'd1,  7'd0,   16'd1,  1'b0, IDLE_LOW},
        '{OP_START, 8'h00, 6'd0,  7'd1,   16'd1,  1'b0, IDLE_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd40, 1'b0, IDLE_LOW},
        '{OP_NOP,   8'h00, 6'd0,  7'd0,   16'd1,  1'b1, IDLE_LOW},
        '{OP_TICK,  8'h00, 6'd0,  7'd0,   16'd3,  1'b1, IDLE_LOW}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbt_in_if  in_ch ();
    mbt_out_if out_ch ();
    mbt_cfg_if cfg_ch ();

    manchester_byte_transmitter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Encoder state as seen from outside, reset values included.
    logic [PER_W-1:0]  m_period   = BIT_PERIOD_RESET;
    logic [BYTE_W-1:0] m_store [MSG_DEPTH];
    logic [TICK_W-1:0] m_elapsed  = '0;
    logic [TICK_W-1:0] m_interval = TICK_W'(BIT_PERIOD_RESET >> 1);
    logic [BIT_W-1:0]  m_bit      = '0;
    logic [SLOT_W-1:0] m_byte     = '0;
    logic              m_second   = 1'b0;
    logic [LEN_W-1:0]  m_len      = '0;
    logic              m_done     = 1'b1;
    logic              m_level    = 1'b0;
    int                m_events   = 0;

    logic [MSG_DEPTH-1:0] written_slots = '0;
    t_result              line_expect_q [$];
    int                   burst_left  = 0;
    int                   busy_items  = 0;
    int                   fail_count  = 0;
    int                   cycle_count = 0;

    function automatic void drive_half_bit();
        logic bit_now;
        m_interval = TICK_W'(m_period >> 1);
        m_elapsed  = '0;
        m_events++;
        bit_now = m_store[m_byte][m_bit];
        if (!m_second) begin
            m_level  = ~bit_now;
            m_second = 1'b1;
        end else begin
            m_level  = bit_now;
            m_second = 1'b0;
            if (m_bit == LAST_BIT) begin
                // byte done: hold the line low for two bit periods
                m_interval = {m_period, 1'b0};
                m_level    = 1'b0;
                if ({1'b0, m_byte} + 7'd1 >= m_len) begin
                    m_done = 1'b1;
                    m_byte = '0;
                end else begin
                    m_byte = m_byte + 6'd1;
                end
            end
            m_bit = m_bit + 3'd1;
        end
    endfunction

    function automatic t_result line_after_item(t_item it);
        t_result r;
        case (it.op)
            OP_WRITE: m_store[it.byte_slot] = it.byte_value;
            OP_START: begin
                m_len  = (it.msg_length > 7'd64) ? 7'd64 : it.msg_length;
                m_done = 1'b0;
            end
            OP_TICK: begin
                if (!m_done) begin
                    if (m_elapsed != TICK_MAX)
                        m_elapsed = m_elapsed + 17'd1;
                    if (m_elapsed >= m_interval)
                        drive_half_bit();
                end
            end
            default: ;
        endcase
        r.line_level = m_level;
        r.finished   = m_done;
        return r;
    endfunction

    function automatic t_item make_item(t_op op, logic [BYTE_W-1:0] v, logic [SLOT_W-1:0] s,
                                        logic [LEN_W-1:0] l);
        t_item it;
        it.op         = op;
        it.byte_value = v;
        it.byte_slot  = s;
        it.msg_length = l;
        return it;
    endfunction

    function automatic t_item any_item(t_op op);
        return make_item(op, BYTE_W'($urandom), SLOT_W'($urandom), LEN_W'($urandom));
    endfunction

    function automatic int stored_prefix();
        int n;
        n = 0;
        while (n < MSG_DEPTH && written_slots[n])
            n++;
        return n;
    endfunction

    task automatic push_item(input t_item it, input logic typed, input t_result want);
        t_result pred;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.op         <= it.op;
        in_ch.byte_value <= it.byte_value;
        in_ch.byte_slot  <= it.byte_slot;
        in_ch.msg_length <= it.msg_length;
        do @(posedge i_clk); while (!in_ch.ready);
        if (it.op == OP_WRITE)
            written_slots[it.byte_slot] = 1'b1;
        // idle ticks and the long waits of a huge bit period do not count
        if (!(it.op == OP_TICK && (m_done || m_interval > 17'd64)))
            busy_items++;
        pred = line_after_item(it);
        line_expect_q.push_back(typed ? want : pred);
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (line_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PER_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        m_period = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Load the bytes, start, then tick until finished with some noise mixed in.
    task automatic send_message(input logic full_store);
        int len_req;
        int fill;
        int pick;
        int top;
        if (full_store) begin
            len_req = $urandom_range(64, 127);
            fill    = MSG_DEPTH;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len_req = 0;
            else if (pick < 3)
                len_req = $urandom_range(5, 16);
            else
                len_req = $urandom_range(1, 4);
            fill = (len_req == 0) ? 1 : len_req;
        end
        for (int s = 0; s < fill; s++)
            push_item(make_item(OP_WRITE, BYTE_W'($urandom), SLOT_W'(s), LEN_W'($urandom)),
                      1'b0, '0);
        push_item(make_item(OP_START, BYTE_W'($urandom), SLOT_W'($urandom), LEN_W'(len_req)),
                  1'b0, '0);
        while (!m_done) begin
            pick = $urandom_range(0, 19);
            if (pick < 17) begin
                push_item(any_item(OP_TICK), 1'b0, '0);
            end else if (pick == 17) begin
                push_item(any_item(OP_NOP), 1'b0, '0);
            end else if (pick == 18) begin
                push_item(any_item(OP_WRITE), 1'b0, '0);
            end else begin
                // restart mid-message: only the length moves
                top = stored_prefix();
                if (top > 6)
                    top = 6;
                push_item(make_item(OP_START, BYTE_W'($urandom), SLOT_W'($urandom),
                                    LEN_W'($urandom_range(0, top))), 1'b0, '0);
            end
        end
    endtask

    task automatic run_phase(input logic [PER_W-1:0] period, input int n_msgs,
                             input logic with_full);
        int pick;
        quiesce();
        write_period(period);
        if (with_full)
            send_message(1'b1);
        repeat (n_msgs) begin
            send_message(1'b0);
            repeat ($urandom_range(0, 3)) begin
                pick = $urandom_range(0, 2);
                push_item(any_item(pick == 0 ? OP_NOP : (pick == 1 ? OP_TICK : OP_WRITE)),
                          1'b0, '0);
            end
        end
    endtask

    // Long bit period: two half-bit events, the second after a half interval of 100 ticks.
    task automatic long_interval_phase();
        int ev_start;
        quiesce();
        write_period(16'd200);
        push_item(make_item(OP_START, BYTE_W'($urandom), SLOT_W'($urandom), 7'd1), 1'b0, '0);
        ev_start = m_events;
        while (m_events < ev_start + 2)
            push_item(any_item(OP_TICK), 1'b0, '0);
    endtask

    initial begin : stimulus
        t_row row;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_NOP;
        in_ch.byte_value = '0;
        in_ch.byte_slot  = '0;
        in_ch.msg_length = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_period(16'd2);
        for (int r = 0; r < $size(DIRECTED_PLAN); r++) begin
            row = DIRECTED_PLAN[r];
            repeat (row.reps)
                push_item(make_item(row.op, row.val, row.slot, row.len), row.typed, row.want);
        end

        run_phase(16'd3, 3, 1'b0);
        long_interval_phase();
        run_phase(16'd0, 2, 1'b1);
        run_phase(16'd1, 3, 1'b0);
        while (busy_items < ITEM_GOAL) begin
            if ($urandom_range(0, 9) == 0)
                run_phase(PER_W'($urandom_range(0, 1)), $urandom_range(2, 5), 1'b0);
            else
                run_phase(PER_W'($urandom_range(2, 6)), $urandom_range(2, 5), 1'b0);
        end

        quiesce();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("manchester_byte_transmitter test passed");
        else
            $display("manchester_byte_transmitter test failed");
        $finish;
    end

    initial begin : receiver
        int   mode;
        int   seg_left;
        int   hold_left;
        int   rx_cycles;
        int   step;
        logic rdy;
        out_ch.ready = 1'b0;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        rx_cycles = 0;
        step      = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            // long hold-off: let the block back up into its input
            if (rx_cycles == HOLD_AT)
                hold_left = HOLD_CYCLES;
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 160);
                step     = 0;
            end
            seg_left--;
            step++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (step % 5) != 0;
                    default: rdy = ($urandom_range(0, 5) == 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (line_expect_q.size() == 0) begin
                $error("result with nothing expected: line_level %0d finished %0d",
                       out_ch.line_level, out_ch.finished);
                fail_count++;
            end else begin
                want = line_expect_q.pop_front();
                if (out_ch.line_level !== want.line_level) begin
                    $error("line_level: expected %0d, got %0d", want.line_level,
                           out_ch.line_level);
                    fail_count++;
                end
                if (out_ch.finished !== want.finished) begin
                    $error("finished: expected %0d, got %0d", want.finished, out_ch.finished);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("manchester_byte_transmitter test failed");
            $finish;
        end
    end

endmodule
